@@ rtl/core/iestk_pkg.sv @@
// Package for the integer evaluation stack: opcode and status codes, widths and divider types.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none
package iestk_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_PEEK = 3'd2,
    OP_READ = 3'd3,
    OP_ADD  = 3'd4,
    OP_SUB  = 3'd5,
    OP_MUL  = 3'd6,
    OP_DIV  = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_RANGE = 3'd3,
    ST_FEW   = 3'd4,
    ST_DIVZ  = 3'd5
  } status_e;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 10;
  localparam int unsigned CntW  = 11;

  // Commands and status between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/iestk_if.sv @@
// Channel interfaces for the integer evaluation stack.
// Depends on iestk_pkg for field widths.
`default_nettype none
interface iestk_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        opcode;
  logic signed [iestk_pkg::WordW-1:0] push_value;
  logic [iestk_pkg::PosW-1:0]        position;
  modport source (output valid, opcode, push_value, position, input ready);
  modport sink   (input valid, opcode, push_value, position, output ready);
endinterface

interface iestk_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [iestk_pkg::WordW-1:0] result_value;
  logic [2:0]                        status;
  logic [iestk_pkg::CntW-1:0]        entry_count;
  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/iestk_div.sv @@
// Radix-2 restoring divider with floor rounding for signed 32-bit words.
// Depends on iestk_pkg. One quotient bit per cycle, then one fixup step.
`default_nettype none
module iestk_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iestk_pkg::div_ctrl_t                ctrl_i,
  input  logic [iestk_pkg::WordW-1:0]         num_i,
  input  logic [iestk_pkg::WordW-1:0]         den_i,
  output iestk_pkg::div_stat_t                stat_o,
  output logic [iestk_pkg::WordW-1:0]         quot_o
);
  localparam int unsigned W = iestk_pkg::WordW;

  logic [W-1:0]   quo_q, quo_d;
  logic [W-1:0]   rem_q, rem_d;
  logic [W-1:0]   den_q, den_d;
  logic           neg_q, neg_d;
  logic [5:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           fix_q, fix_d;
  logic           done_q, done_d;
  logic [W:0]     trial;
  logic [W:0]     shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    fix_d   = 1'b0;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[W-1]};
    trial   = shifted - {1'b0, den_q};
    if (ctrl_i.start) begin
      // Latch magnitudes and the sign of the quotient.
      quo_d  = num_i[W-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i[W-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[W-1] ^ den_i[W-1];
      rem_d  = '0;
      cnt_d  = 6'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // One restoring step: shift in the next numerator bit.
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        fix_d  = 1'b1;
      end
    end else if (fix_q) begin
      // Negate for a negative quotient, and round down on a remainder.
      if (neg_q) begin
        quo_d = (rem_q != '0) ? ~quo_q : (~quo_q + 1'b1);
      end
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fix_q  <= fix_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign stat_o.busy = busy_q | fix_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
endmodule
`default_nettype wire

@@ rtl/core/integer_evaluation_stack_unit.sv @@
// Top level of the integer evaluation stack: sequencer, word memory, ALU.
// Depends on iestk_pkg, iestk_if and iestk_div.
//
//  Channel | Dir | Beat contents
//  in_i    | in  | opcode, push_value, position
//  out_o   | out | result_value, status, entry_count
//
// Push writes the memory as it is checked; pop, peek and read do one read; add,
// subtract and multiply do two reads of the single memory port, then the write back.
// Divide runs the one-bit-a-cycle divider between the reads and the write back.
// Reset clears only the entry count and control; the memory needs no clearing.
// One operation at a time; in_i is not ready until the result beat is taken.
`default_nettype none
module integer_evaluation_stack_unit #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  iestk_in_if.sink    in_i,
  iestk_out_if.source out_o
);
  localparam int unsigned W  = iestk_pkg::WordW;
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  // The count is at least as wide as a position so range checks never truncate.
  localparam int unsigned FW = ($clog2(STACK_DEPTH + 1) > iestk_pkg::PosW) ?
                               $clog2(STACK_DEPTH + 1) : iestk_pkg::PosW;
  localparam int unsigned CW = iestk_pkg::CntW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD_A  = 7'b0000010,
    S_RD_B  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WB    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]  mem_wdata;
  logic          mem_re;

  logic [FW-1:0] fill_q, fill_d;
  logic [2:0]    op_q, op_d;
  logic [W-1:0]  pv_q, pv_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  res_q, res_d;
  logic [2:0]    st_q, st_d;
  logic [FW-1:0] pos_ext;
  logic [FW-1:0] pos_q, pos_d;

  iestk_pkg::div_ctrl_t div_ctrl;
  iestk_pkg::div_stat_t div_stat;
  logic [W-1:0]         div_quot;

  iestk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (rdata_q),
    .den_i  (a_q),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  assign pos_ext = FW'(in_i.position);

  // Single-port word memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    op_d      = op_q;
    pv_d      = pv_q;
    a_d       = a_q;
    res_d     = res_q;
    st_d      = st_q;
    pos_d     = pos_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = fill_q[AW-1:0];
    mem_raddr = fill_q[AW-1:0];
    mem_wdata = pv_q;
    div_ctrl.start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d  = in_i.opcode;
          pv_d  = in_i.push_value;
          pos_d = pos_ext;
          res_d = '0;
          st_d  = iestk_pkg::ST_OK;
          state_d = S_RD_A;
        end
      end
      S_RD_A: begin
        // Check the operation and issue the first read, or the write for a push.
        state_d = S_OUT;
        unique case (op_q)
          iestk_pkg::OP_PUSH: begin
            if (fill_q >= FW'(STACK_DEPTH)) begin
              st_d = iestk_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              fill_d = fill_q + 1'b1;
            end
          end
          iestk_pkg::OP_POP: begin
            if (fill_q == '0) begin
              st_d = iestk_pkg::ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(fill_q - 1'b1);
              fill_d    = fill_q - 1'b1;
              state_d   = S_EXEC;
            end
          end
          iestk_pkg::OP_PEEK, iestk_pkg::OP_READ: begin
            if (pos_q >= fill_q) begin
              st_d = iestk_pkg::ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = (op_q == iestk_pkg::OP_PEEK) ?
                          AW'(fill_q - pos_q - 1'b1) : AW'(pos_q);
              state_d   = S_EXEC;
            end
          end
          default: begin
            if (fill_q < FW'(2)) begin
              st_d = iestk_pkg::ST_FEW;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(fill_q - 1'b1);
              state_d   = S_RD_B;
            end
          end
        endcase
      end
      S_RD_B: begin
        a_d       = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = AW'(fill_q - FW'(2));
        fill_d    = fill_q - FW'(2);
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_WB;
        unique case (op_q)
          iestk_pkg::OP_ADD: res_d = rdata_q + a_q;
          iestk_pkg::OP_SUB: res_d = rdata_q - a_q;
          iestk_pkg::OP_MUL: res_d = W'(rdata_q * a_q);
          iestk_pkg::OP_DIV: begin
            if (a_q == '0) begin
              st_d    = iestk_pkg::ST_DIVZ;
              state_d = S_OUT;
            end else begin
              div_ctrl.start = 1'b1;
              state_d = S_DIV;
            end
          end
          default: begin
            res_d   = rdata_q;
            state_d = S_OUT;
          end
        endcase
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_d   = div_quot;
          state_d = S_WB;
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_wdata = res_q;
        fill_d    = fill_q + 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    pv_q  <= pv_d;
    a_q   <= a_d;
    res_q <= res_d;
    st_q  <= st_d;
    pos_q <= pos_d;
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = (state_q == S_OUT);
  assign out_o.result_value = (st_q == iestk_pkg::ST_OK) ? res_q : '0;
  assign out_o.status       = st_q;
  assign out_o.entry_count  = CW'(fill_q);
endmodule
`default_nettype wire

@@ rtl/core/iestk_checker.sv @@
// Port-level checker for the integer evaluation stack, bound to the top level.
// Depends on iestk_pkg for status codes.
`default_nettype none
module iestk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] result_value_i,
  input logic [2:0]  status_i,
  input logic [10:0] entry_count_i
);
  // Input is never taken while a result beat waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while result pending");

  // An error result carries a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != iestk_pkg::ST_OK |-> result_value_i == '0)
    else $error("nonzero value on error");

  // Status codes stay in the defined range.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= iestk_pkg::ST_DIVZ)
    else $error("bad status");

  // A pending result holds its entry count and status.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(entry_count_i) && $stable(status_i))
    else $error("result changed while stalled");
endmodule

bind integer_evaluation_stack_unit iestk_checker u_iestk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_value_i (out_o.result_value),
  .status_i       (out_o.status),
  .entry_count_i  (out_o.entry_count)
);
`default_nettype wire
